FILE: src/llts_pkg.sv
package llts_pkg;

  // Line length limit; positions saturate one below min(LineMax, 4096)
  localparam int unsigned LineMax   = 4096;
  localparam int unsigned PosCapInt = ((LineMax < 4096) ? LineMax : 4096) - 1;
  localparam logic [11:0] PosCap    = 12'(PosCapInt);
  localparam logic [12:0] LenCap    = 13'd4096;

  // Depth of the queue between front and back (at least 2)
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    TokNum = 3'd0,
    TokId  = 3'd1,
    TokSym = 3'd2,
    TokKey = 3'd3,
    TokBad = 3'd4
  } tok_type_e;

  // Input beat
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  token_type;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        line_overflow;
    logic        last;
  } result_t;

  // One token as the front produces it, before the last flag is known
  typedef struct packed {
    logic [2:0]  token_type;
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic        line_overflow;
  } tok_t;

  // All tokens caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } rec_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: src/llts_front.sv
module llts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  llts_pkg::in_beat_t in_i,
  output logic               rec_valid_o,
  output llts_pkg::rec_t     rec_o
);

  typedef enum logic [2:0] {
    ModeIdle = 3'b001,
    ModeNum  = 3'b010,
    ModeId   = 3'b100
  } mode_e;

  typedef enum logic [5:0] {
    KwNone = 6'b000001,
    KwI    = 6'b000010,
    KwW    = 6'b000100,
    KwWh   = 6'b001000,
    KwWhi  = 6'b010000,
    KwWhil = 6'b100000
  } kw_e;

  mode_e       mode_q, mode_d;
  kw_e         kw_q, kw_d, kw_adv;
  logic        kw_hit;
  logic [11:0] start_q, start_d;
  logic [11:0] pos_q, pos_d;
  logic [12:0] len_q, len_d, len_grown;
  logic        ovf_q, ovf_d;
  logic        cap_q, cap_d;

  logic [7:0]  c;
  logic        is_digit, is_alpha, is_word, is_sym, is_skip;
  logic        ovf_now, done;
  logic        pend_v, own_v, flush_v;
  llts_pkg::tok_t pend_tok, own_tok, flush_tok;

  assign c        = in_i.char_in;
  assign is_digit = c inside {["0":"9"]};
  assign is_alpha = c inside {["a":"z"], ["A":"Z"]};
  assign is_word  = is_alpha || is_digit || (c == "_");
  assign is_sym   = c inside {"+", "-", "*", "/", "=", "(", ")", "<", ">", "{", "}", ";"};
  assign is_skip  = c inside {" ", 8'h0D, 8'h0A};
  assign ovf_now  = cap_q | ovf_q;
  assign len_grown = (len_q == llts_pkg::LenCap) ? len_q : len_q + 13'd1;

  // Keyword prefix tracker
  always_comb begin
    kw_adv = KwNone;
    kw_hit = 1'b0;
    case (kw_q)
      KwI:    kw_hit = (c == "f");
      KwW:    kw_adv = (c == "h") ? KwWh : KwNone;
      KwWh:   kw_adv = (c == "i") ? KwWhi : KwNone;
      KwWhi:  kw_adv = (c == "l") ? KwWhil : KwNone;
      KwWhil: kw_hit = (c == "e");
      default: kw_adv = KwNone;
    endcase
  end

  // Classification and state update for one byte
  always_comb begin
    mode_d  = mode_q;
    kw_d    = kw_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    cap_d   = cap_q;
    done    = 1'b0;
    pend_v  = 1'b0;
    own_v   = 1'b0;
    flush_v = 1'b0;
    pend_tok  = '{token_type: llts_pkg::TokNum, token_start: start_q,
                  token_length: len_q, line_overflow: ovf_now};
    own_tok   = '{token_type: llts_pkg::TokSym, token_start: pos_q,
                  token_length: 13'd1, line_overflow: ovf_now};
    flush_tok = pend_tok;

    // position with saturation
    if (cap_q) begin
      ovf_d = 1'b1;
    end else if (pos_q >= llts_pkg::PosCap) begin
      pos_d = llts_pkg::PosCap;
      cap_d = 1'b1;
    end else begin
      pos_d = pos_q + 12'd1;
    end

    // pending run
    case (mode_q)
      ModeNum: begin
        if (is_digit) begin
          len_d = len_grown;
          done  = 1'b1;
        end else begin
          pend_v = 1'b1;
          mode_d = ModeIdle;
        end
      end
      ModeId: begin
        if (is_word) begin
          len_d = len_grown;
          done  = 1'b1;
          if (kw_hit) begin
            pend_v                = 1'b1;
            pend_tok.token_type   = llts_pkg::TokKey;
            pend_tok.token_length = len_grown;
            mode_d                = ModeIdle;
            kw_d                  = KwNone;
          end else begin
            kw_d = kw_adv;
          end
        end else begin
          pend_v              = 1'b1;
          pend_tok.token_type = llts_pkg::TokId;
          mode_d              = ModeIdle;
          kw_d                = KwNone;
        end
      end
      default: ;
    endcase

    // this byte on its own
    if (!done) begin
      if (is_skip) begin
        own_v = 1'b0;
      end else if (is_sym) begin
        own_v = 1'b1;
      end else if (c == "0") begin
        own_v              = 1'b1;
        own_tok.token_type = llts_pkg::TokNum;
      end else if (is_digit) begin
        mode_d  = ModeNum;
        start_d = pos_q;
        len_d   = 13'd1;
      end else if (is_alpha || (c == "_")) begin
        mode_d  = ModeId;
        start_d = pos_q;
        len_d   = 13'd1;
        kw_d    = (c == "i") ? KwI : ((c == "w") ? KwW : KwNone);
      end else begin
        own_v              = 1'b1;
        own_tok.token_type = llts_pkg::TokBad;
      end
    end

    // end of line flushes the run and restarts the line
    if (in_i.end_of_line) begin
      flush_tok.token_start  = start_d;
      flush_tok.token_length = len_d;
      if (mode_d == ModeNum) begin
        flush_v              = 1'b1;
        flush_tok.token_type = llts_pkg::TokNum;
      end else if (mode_d == ModeId) begin
        flush_v              = 1'b1;
        flush_tok.token_type = llts_pkg::TokId;
      end
      mode_d = ModeIdle;
      kw_d   = KwNone;
      pos_d  = '0;
      cap_d  = 1'b0;
      ovf_d  = 1'b0;
    end
  end

  // Pack the byte's tokens in order
  always_comb begin
    rec_o.cnt = 2'(pend_v) + 2'(own_v) + 2'(flush_v);
    if (pend_v) begin
      rec_o.tok0 = pend_tok;
      rec_o.tok1 = own_v ? own_tok : flush_tok;
    end else begin
      rec_o.tok0 = own_v ? own_tok : flush_tok;
      rec_o.tok1 = flush_tok;
    end
  end

  assign rec_valid_o = acc_i && (rec_o.cnt != 2'd0);

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      kw_q    <= KwNone;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
      cap_q   <= 1'b0;
    end else if (acc_i) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
      cap_q   <= cap_d;
    end
  end

endmodule

FILE: src/llts_queue.sv
module llts_queue #(
  parameter int unsigned Depth = llts_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  llts_pkg::rec_t    wr_data_i,
  input  logic              rd_i,
  output llts_pkg::rec_t    rd_data_o,
  output llts_pkg::q_stat_t stat_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  llts_pkg::rec_t   mem_q [Depth];
  logic [AddrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastAddr) ? '0 : wptr_q + AddrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastAddr) ? '0 : rptr_q + AddrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: src/llts_back.sv
module llts_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llts_pkg::rec_t    head_i,
  input  llts_pkg::q_stat_t stat_i,
  input  logic              pop_i,
  output logic              q_rd_o,
  output logic              empty_o,
  output llts_pkg::result_t result_o
);

  logic           sel_q;
  logic           last;
  logic           take;
  llts_pkg::tok_t tok;

  // Walk the tokens of the head record, one per beat
  assign tok     = sel_q ? head_i.tok1 : head_i.tok0;
  assign last    = sel_q || (head_i.cnt == 2'd1);
  assign empty_o = stat_i.empty;
  assign take    = pop_i && !stat_i.empty;
  assign q_rd_o  = take && last;

  assign result_o = '{token_type:    tok.token_type,
                      token_start:   tok.token_start,
                      token_length:  tok.token_length,
                      line_overflow: tok.line_overflow,
                      last:          last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= !last;
    end
  end

endmodule

FILE: src/line_lexer_token_scanner.sv
// Channel  Direction  Beat type           Accepted when
// -------  ---------  ------------------  --------------------
// input    in         llts_pkg::in_beat_t  push && !full
// result   out        llts_pkg::result_t   pop && !empty
//
// One byte per cycle enters the front while full is low; its scanner state is registered.
// A byte's tokens (zero to two) are stored in the queue as one record and
// leave one per beat, so a byte giving two tokens takes two result beats.
// The queue between front and back (QueueDepth records) absorbs result stalls;
// full rises only when it holds QueueDepth records. Reset is asynchronous and
// returns the scanner to the start of a line with an empty queue.
module line_lexer_token_scanner #(
  parameter int unsigned QueueDepth = llts_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  llts_pkg::in_beat_t in_i,
  output logic               empty,
  input  logic               pop,
  output llts_pkg::result_t  result_o
);

  llts_pkg::rec_t    rec, head;
  llts_pkg::q_stat_t stat;
  logic              rec_valid;
  logic              acc;
  logic              q_rd;

  assign full = stat.full;
  assign acc  = push && !stat.full;

  llts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .in_i        (in_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  llts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_valid),
    .wr_data_i (rec),
    .rd_i      (q_rd),
    .rd_data_o (head),
    .stat_o    (stat)
  );

  llts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .stat_i   (stat),
    .pop_i    (pop),
    .q_rd_o   (q_rd),
    .empty_o  (empty),
    .result_o (result_o)
  );

endmodule
